FILE: rtl/gpdf_pkg.sv
// Shared types and constants for the normal density / cumulative area evaluator.
// Used by gpdf_recip, gpdf_exp, gaussian_pdf_cdf_eval_top and the testbench; no dependencies.
package gpdf_pkg;

  // configuration register select (paddr[2])
  localparam logic REG_MEAN      = 1'b0;
  localparam logic REG_INV_SIGMA = 1'b1;

  // fixed-point constants
  localparam logic [30:0] INV_SQRT_2PI_Q32 = 31'd1713444047;
  localparam logic [29:0] P_Q32            = 30'd994894385;
  localparam logic [31:0] LN2_Q32          = 32'd2977044472;
  localparam logic [26:0] LOG2E_Q26        = 27'd96817626;

  localparam logic signed [33:0] B1_Q30 = 34'sd342933307;
  localparam logic signed [33:0] B2_Q30 = -34'sd382857446;
  localparam logic signed [33:0] B3_Q30 = 34'sd1912847370;
  localparam logic signed [33:0] B4_Q30 = -34'sd1955558716;
  localparam logic signed [33:0] B5_Q30 = 34'sd1428371292;

  // ceil(2^36 / k): exact floor division by k for dividends below 2^32
  localparam int RECIP_SH = 36;
  localparam logic [35:0] RECIP_TAB [2:13] = '{
    36'd34359738368, 36'd22906492246, 36'd17179869184, 36'd13743895348,
    36'd11453246123, 36'd9817068106,  36'd8589934592,  36'd7635497416,
    36'd6871947674,  36'd6247225158,  36'd5726623062,  36'd5286113596
  };

  // reciprocal divider: 31 quotient bits, four per stage
  localparam int Q_BITS      = 31;
  localparam int DIV_STEPS   = 4;
  localparam int DIV_STAGES  = (Q_BITS + DIV_STEPS - 1) / DIV_STEPS;

  // exponential: two setup stages, two per Taylor term, one final
  localparam int EXP_TERMS   = 13;
  localparam int EXP_LAT     = 2 + 2 * EXP_TERMS + 1;

  // front stages, divider, exponential, polynomial/output stages
  localparam int LATENCY     = 5 + DIV_STAGES + EXP_LAT + 7;

  typedef struct packed {
    logic        req;
    logic        zneg;
    logic [38:0] u;
  } recip_tag_t;

  typedef struct packed {
    logic        req;
    logic        zneg;
    logic [30:0] t;
  } exp_tag_t;

endpackage

FILE: rtl/gpdf_recip.sv
// Pipelined restoring divider: t = 2^46 / den, one quotient bit per step.
// Depends on gpdf_pkg; a sideband tag travels with each request.
module gpdf_recip #(
  parameter int TAG_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [18:0]       in_den,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [30:0]       out_t,
  output logic [TAG_W-1:0]  out_tag
);
  import gpdf_pkg::*;

  logic              v_r   [DIV_STAGES];
  logic [18:0]       rem_r [DIV_STAGES];
  logic [30:0]       q_r   [DIV_STAGES];
  logic [18:0]       den_r [DIV_STAGES];
  logic [TAG_W-1:0]  tag_r [DIV_STAGES];
  logic [18:0]       rem_nxt [DIV_STAGES];
  logic [30:0]       q_nxt   [DIV_STAGES];

  always_comb begin
    logic [19:0] r;
    logic [30:0] q;
    logic [18:0] dv;
    for (int s = 0; s < DIV_STAGES; s++) begin
      // 2^46 / den: bits above quotient bit 30 are zero since den >= 2^16
      r  = (s == 0) ? 20'h08000 : {1'b0, rem_r[(s == 0) ? 0 : s - 1]};
      q  = (s == 0) ? '0 : q_r[(s == 0) ? 0 : s - 1];
      dv = (s == 0) ? in_den : den_r[(s == 0) ? 0 : s - 1];
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (s * DIV_STEPS + j < Q_BITS) begin
          r = {r[18:0], 1'b0};
          if (r >= {1'b0, dv}) begin
            r = r - {1'b0, dv};
            q = {q[29:0], 1'b1};
          end else begin
            q = {q[29:0], 1'b0};
          end
        end
      end
      rem_nxt[s] = r[18:0];
      q_nxt[s]   = q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) v_r[s] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int s = 1; s < DIV_STAGES; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    den_r[0] <= in_den;
    tag_r[0] <= in_tag;
    for (int s = 1; s < DIV_STAGES; s++) begin
      den_r[s] <= den_r[s-1];
      tag_r[s] <= tag_r[s-1];
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_r[s] <= rem_nxt[s];
      q_r[s]   <= q_nxt[s];
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign out_t     = q_r[DIV_STAGES-1];
  assign out_tag   = tag_r[DIV_STAGES-1];

endmodule

FILE: rtl/gpdf_exp.sv
// Pipelined exp(-u), u and result with 32 fraction bits: 2^-n * exp(-f*ln2),
// the second factor by a 13-term Taylor series. Depends on gpdf_pkg.
module gpdf_exp #(
  parameter int TAG_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [38:0]       in_u,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [32:0]       out_e,
  output logic [TAG_W-1:0]  out_tag
);
  import gpdf_pkg::*;

  localparam int LAST = 2 * EXP_TERMS + 1;  // stage index of the last term

  logic              v_r    [LAST+1];
  logic [5:0]        n_r    [LAST+1];
  logic              zero_r [LAST+1];
  logic [TAG_W-1:0]  tag_r  [LAST+1];
  logic [31:0]       f_r;
  logic [31:0]       g_r    [1:LAST];
  logic [31:0]       prod_r [1:EXP_TERMS];
  logic [31:0]       term_r [1:EXP_TERMS];
  logic signed [34:0] sum_a_r [1:EXP_TERMS];
  logic signed [34:0] sum_b_r [1:EXP_TERMS];

  logic [63:0]       v_prod;
  logic signed [34:0] fin_sum;
  logic [32:0]       fin_mag;
  logic              out_valid_r;
  logic [32:0]       out_e_r;
  logic [TAG_W-1:0]  out_tag_r;

  assign v_prod  = 64'(in_u[36:0]) * 64'(LOG2E_Q26);
  assign fin_sum = sum_b_r[EXP_TERMS] - $signed({3'b0, term_r[EXP_TERMS]});
  assign fin_mag = fin_sum[34] ? '0 : fin_sum[32:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= LAST; i++) v_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int i = 1; i <= LAST; i++) v_r[i] <= v_r[i-1];
      out_valid_r <= v_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    // stage 0: scale by log2(e), split into integer and fraction
    n_r[0]    <= v_prod[63:58];
    f_r       <= v_prod[57:26];
    zero_r[0] <= (in_u[38:37] != 2'b00);
    tag_r[0]  <= in_tag;
    for (int i = 1; i <= LAST; i++) begin
      n_r[i]    <= n_r[i-1];
      zero_r[i] <= zero_r[i-1];
      tag_r[i]  <= tag_r[i-1];
    end
    // stage 1: fraction back to natural log units
    g_r[1] <= 32'((64'(f_r) * 64'(LN2_Q32)) >> 32);
    for (int i = 2; i <= LAST; i++) g_r[i] <= g_r[i-1];

    // term k: multiply by g on even stages, divide by k on odd stages
    prod_r[1]  <= g_r[1];
    sum_a_r[1] <= 35'sh1_0000_0000;
    term_r[1]  <= prod_r[1];
    sum_b_r[1] <= sum_a_r[1];
    for (int k = 2; k <= EXP_TERMS; k++) begin
      prod_r[k] <= 32'((64'(term_r[k-1]) * 64'(g_r[2*k-1])) >> 32);
      if ((k & 1) == 0) sum_a_r[k] <= sum_b_r[k-1] - $signed({3'b0, term_r[k-1]});
      else              sum_a_r[k] <= sum_b_r[k-1] + $signed({3'b0, term_r[k-1]});
      term_r[k]  <= 32'((68'(prod_r[k]) * 68'(RECIP_TAB[k])) >> RECIP_SH);
      sum_b_r[k] <= sum_a_r[k];
    end

    out_e_r   <= zero_r[LAST] ? '0 : (fin_mag >> n_r[LAST]);
    out_tag_r <= tag_r[LAST];
  end

  assign out_valid = out_valid_r;
  assign out_e     = out_e_r;
  assign out_tag   = out_tag_r;

endmodule

FILE: rtl/gaussian_pdf_cdf_eval_top.sv
// Normal distribution evaluator: density or cumulative area of a Q16.16 point.
// Depends on gpdf_pkg, gpdf_recip and gpdf_exp.
//
// Usage:
//   Input: drive in_req_type (0 density, 1 area) and in_x_value with start high;
//   the request is taken at that edge. busy is always low, so one request can be
//   taken every cycle.
//   Output: out_valid pulses for one cycle with out_result_value and
//   out_saturated. The receiver cannot hold results off; none is needed since
//   the pipeline never stops.
//   Pipeline: 5 front stages (difference, |z| multiply, scaling, square, t
//   denominator), 8 divider stages for t, 29 exponential stages (13 Taylor
//   terms, two stages each) and 7 polynomial and output stages. Throughput:
//   one item per cycle. Config: APB writes at 0x0 (mean) and 0x4 (inv_sigma);
//   the user must make them only while idle; the block does not enforce it.
//   Reset: synchronous, active low; clears all valid bits, mean to 0 and
//   inv_sigma to 1.0. Results in flight at reset are dropped.
module gaussian_pdf_cdf_eval_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [31:0] in_x_value,
  output logic        out_valid,
  output logic [31:0] out_result_value,
  output logic        out_saturated,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gpdf_pkg::*;

  localparam int ZM_W = 65 - FRAC_BITS;

  function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                 input logic [30:0] t);
    logic [33:0] mag;
    logic [64:0] p;
    logic [33:0] r;
    mag = a[33] ? 34'(-a) : 34'(a);
    p   = 65'(mag) * 65'(t);
    r   = 34'(p >> 30);
    return a[33] ? -$signed(r) : $signed(r);
  endfunction

  // configuration
  logic [31:0] mean_r, inv_sigma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r      <= '0;
      inv_sigma_r <= 32'(1) << FRAC_BITS;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_MEAN:      mean_r      <= pwdata;
        REG_INV_SIGMA: inv_sigma_r <= pwdata;
        default:       mean_r      <= mean_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MEAN:      prdata = mean_r;
      REG_INV_SIGMA: prdata = inv_sigma_r;
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign busy   = 1'b0;

  // front stages
  logic              s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic              s1_q_r, s2_q_r, s3_q_r, s4_q_r, s5_q_r;
  logic              s1_n_r, s2_n_r, s3_n_r, s4_n_r, s5_n_r;
  logic [32:0]       s1_dmag_r;
  logic [ZM_W-1:0]   zmag_r;
  logic [31:0]       zq_r;
  logic [38:0]       s4_u_r, s5_u_r;
  logic [33:0]       pz_r;
  logic [18:0]       den_r;
  logic signed [32:0] diff;
  logic [31:0]       zq_sh;

  assign diff = $signed({in_x_value[31], in_x_value}) - $signed({mean_r[31], mean_r});

  generate
    if (FRAC_BITS <= 28) begin : g_zq_up
      assign zq_sh = 32'(zmag_r << (28 - FRAC_BITS));
    end else begin : g_zq_dn
      assign zq_sh = 32'(zmag_r >> (FRAC_BITS - 28));
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0; s4_v_r <= 1'b0; s5_v_r <= 1'b0;
    end else begin
      s1_v_r <= start && !busy;
      s2_v_r <= s1_v_r; s3_v_r <= s2_v_r; s4_v_r <= s3_v_r; s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_q_r    <= in_req_type;
    s1_n_r    <= diff[32];
    s1_dmag_r <= diff[32] ? 33'(-diff) : 33'(diff);
    s2_q_r <= s1_q_r; s3_q_r <= s2_q_r; s4_q_r <= s3_q_r; s5_q_r <= s4_q_r;
    s2_n_r <= s1_n_r; s3_n_r <= s2_n_r; s4_n_r <= s3_n_r; s5_n_r <= s4_n_r;
    zmag_r <= ZM_W'((65'(s1_dmag_r) * 65'(inv_sigma_r)) >> FRAC_BITS);
    // |z| at or above 16 clamps to just below 16 (Q4.28)
    zq_r   <= (zmag_r[ZM_W-1:FRAC_BITS+4] != '0) ? 32'hFFFF_FFFF : zq_sh;
    s4_u_r <= 39'((64'(zq_r) * 64'(zq_r)) >> 25);
    pz_r   <= 34'((64'(zq_r) * 64'(P_Q32)) >> 28);
    s5_u_r <= s4_u_r;
    den_r  <= 19'((35'(pz_r) + 35'h1_0000_0000) >> 16);
  end

  // t = 1 / (1 + p|z|)
  recip_tag_t rc_in_tag, rc_out_tag;
  logic       rc_v;
  logic [30:0] rc_t;

  assign rc_in_tag = '{req: s5_q_r, zneg: s5_n_r, u: s5_u_r};

  gpdf_recip #(.TAG_W($bits(recip_tag_t))) u_recip (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s5_v_r),
    .in_den    (den_r),
    .in_tag    (rc_in_tag),
    .out_valid (rc_v),
    .out_t     (rc_t),
    .out_tag   (rc_out_tag)
  );

  // exp(-z^2/2)
  exp_tag_t   ex_in_tag, ex_out_tag;
  logic       ex_v;
  logic [32:0] ex_e;

  assign ex_in_tag = '{req: rc_out_tag.req, zneg: rc_out_tag.zneg, t: rc_t};

  gpdf_exp #(.TAG_W($bits(exp_tag_t))) u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rc_v),
    .in_u      (rc_out_tag.u),
    .in_tag    (ex_in_tag),
    .out_valid (ex_v),
    .out_e     (ex_e),
    .out_tag   (ex_out_tag)
  );

  // density scaling, Horner polynomial in t, tail and area
  logic              rv_r  [1:6];
  logic              rq_r  [1:6];
  logic              rz_r  [1:6];
  logic [31:0]       phi_r [1:5];
  logic [31:0]       dens_r [2:6];
  logic [30:0]       rt_r  [1:4];
  logic signed [33:0] acc_r [1:5];
  logic [34:0]       tail_r;
  logic [32:0]       acc_pos;
  logic [32:0]       tail_c, area, res_nxt;
  logic              out_valid_r, out_sat_r;
  logic [31:0]       out_res_r;

  assign acc_pos = acc_r[5][33] ? '0 : acc_r[5][32:0];

  always_comb begin
    tail_c  = (tail_r > 35'h1_0000_0000) ? 33'h1_0000_0000 : tail_r[32:0];
    area    = rz_r[6] ? tail_c : 33'h1_0000_0000 - tail_c;
    res_nxt = rq_r[6] ? (area >> (32 - FRAC_BITS)) : {1'b0, dens_r[6]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 6; i++) rv_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rv_r[1] <= ex_v;
      for (int i = 2; i <= 6; i++) rv_r[i] <= rv_r[i-1];
      out_valid_r <= rv_r[6];
    end
  end

  always_ff @(posedge clk) begin
    rq_r[1] <= ex_out_tag.req;
    rz_r[1] <= ex_out_tag.zneg;
    for (int i = 2; i <= 6; i++) begin
      rq_r[i] <= rq_r[i-1];
      rz_r[i] <= rz_r[i-1];
    end
    phi_r[1] <= 32'((64'(INV_SQRT_2PI_Q32) * 64'(ex_e)) >> 32);
    for (int i = 2; i <= 5; i++) phi_r[i] <= phi_r[i-1];
    rt_r[1] <= ex_out_tag.t;
    for (int i = 2; i <= 4; i++) rt_r[i] <= rt_r[i-1];
    dens_r[2] <= 32'((64'(inv_sigma_r) * 64'(phi_r[1])) >> 32);
    for (int i = 3; i <= 6; i++) dens_r[i] <= dens_r[i-1];

    acc_r[1] <= mul_q30(B5_Q30, ex_out_tag.t) + B4_Q30;
    acc_r[2] <= mul_q30(acc_r[1], rt_r[1]) + B3_Q30;
    acc_r[3] <= mul_q30(acc_r[2], rt_r[2]) + B2_Q30;
    acc_r[4] <= mul_q30(acc_r[3], rt_r[3]) + B1_Q30;
    acc_r[5] <= mul_q30(acc_r[4], rt_r[4]);
    // truncation can leave the polynomial slightly negative: use 0
    tail_r   <= 35'((66'(phi_r[5]) * 66'(acc_pos)) >> 30);

    out_sat_r <= res_nxt[32];
    out_res_r <= res_nxt[32] ? 32'hFFFF_FFFF : res_nxt[31:0];
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_saturated    = out_sat_r;

  // fixed latency, both directions
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LATENCY out_valid)
    else $error("request did not produce a result after the pipeline latency");

  a_latency_rev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without a matching request");

  a_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_saturated)
    else $error("result clipped; widths allow no overflow");

  a_area_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r[6] && rq_r[6] |=> ({1'b0, out_result_value} <= (33'(1) << FRAC_BITS)))
    else $error("cumulative area above one");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking bench for gaussian_pdf_cdf_eval_top: directed table, then random requests.
// Depends on the RTL top and gpdf_pkg; expected values come from the table or a bit-exact predictor.
module testbench;

  localparam logic [63:0] ONE_Q32   = 64'h1_0000_0000;
  localparam logic [63:0] RSQ2PI    = 64'd1713444047;
  localparam logic [63:0] PCOEF     = 64'd994894385;
  localparam logic [63:0] LN2       = 64'd2977044472;
  localparam logic [63:0] LOG2E     = 64'd96817626;
  localparam longint      C1        = 342933307;
  localparam longint      C2        = -382857446;
  localparam longint      C3        = 1912847370;
  localparam longint      C4        = -1955558716;
  localparam longint      C5        = 1428371292;
  localparam int          FB        = 16;
  localparam int          DRAIN     = 60;
  localparam int          MAX_CYC   = 400000;
  localparam int          PHASES    = 8;
  localparam int          PER_PHASE = 200;

  typedef struct {
    logic [31:0] val;
    logic        sat;
  } eval_t;

  typedef struct {
    logic        req;
    logic [31:0] x;
    logic        typed;
    logic [31:0] want;
  } vec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_req_type = 1'b0;
  logic [31:0] in_x_value = '0;
  logic        out_valid;
  logic [31:0] out_result_value;
  logic        out_saturated;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] cur_mean;
  logic [31:0] cur_isig;
  eval_t       pending[$];
  int          errors = 0;
  int          cycles = 0;
  bit          no_gaps = 1'b0;

  gaussian_pdf_cdf_eval_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_x_value(in_x_value),
    .out_valid(out_valid), .out_result_value(out_result_value),
    .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    errors++;
  endtask

  // exp(-u), both in Q32
  function automatic logic [63:0] exp_decay(input logic [63:0] u);
    logic [63:0] v, f, g, term;
    longint      acc;
    int          n;
    if (u >= (64'd32 << 32)) return 64'd0;
    v = (u * LOG2E) >> 26;
    n = int'(v >> 32);
    f = v & 64'hFFFF_FFFF;
    g = (f * LN2) >> 32;
    term = ONE_Q32;
    acc = longint'(ONE_Q32);
    for (int k = 1; k <= 13; k++) begin
      term = ((term * g) >> 32) / k;
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (n >= 63) return 64'd0;
    return 64'(acc) >> n;
  endfunction

  function automatic longint horner_mul(input longint a, input logic [63:0] t);
    logic        neg;
    logic [63:0] m, r;
    neg = a < 0;
    m = neg ? 64'(-a) : 64'(a);
    r = (m * t) >> 30;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic eval_t normal_eval(input logic req, input logic [31:0] x);
    longint      d;
    logic        zneg;
    logic [63:0] dmag, zmag, zq, e, phi, res, den, t, tail, area;
    longint      acc;
    eval_t       o;
    d = longint'($signed(x)) - longint'($signed(cur_mean));
    zneg = d < 0;
    dmag = zneg ? 64'(-d) : 64'(d);
    zmag = (dmag * {32'd0, cur_isig}) >> FB;
    if (zmag >= (64'd16 << FB)) zq = 64'hFFFF_FFFF;
    else zq = zmag << (28 - FB);
    e = exp_decay((zq * zq) >> 25);
    phi = (RSQ2PI * e) >> 32;
    if (!req) begin
      res = ({32'd0, cur_isig} * phi) >> 32;
    end else begin
      den = (ONE_Q32 + ((PCOEF * zq) >> 28)) >> 16;
      t = (64'd1 << 46) / den;
      acc = C5;
      acc = horner_mul(acc, t) + C4;
      acc = horner_mul(acc, t) + C3;
      acc = horner_mul(acc, t) + C2;
      acc = horner_mul(acc, t) + C1;
      acc = horner_mul(acc, t);
      if (acc < 0) acc = 0;
      tail = (phi * 64'(acc)) >> 30;
      if (tail > ONE_Q32) tail = ONE_Q32;
      area = zneg ? tail : ONE_Q32 - tail;
      res = area >> (32 - FB);
    end
    o.sat = res > 64'hFFFF_FFFF;
    o.val = o.sat ? 32'hFFFF_FFFF : res[31:0];
    return o;
  endfunction

  task automatic cfg_write(input logic idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == gpdf_pkg::REG_MEAN) cur_mean = val;
    else cur_isig = val;
  endtask

  // one request; expectation is queued once acceptance is certain.
  // start stays high on return so requests can follow back to back.
  task automatic send(input logic req, input logic [31:0] x, input logic typed,
                      input logic [31:0] want);
    logic  b;
    eval_t exp_r;
    while (!no_gaps && $urandom_range(99) < 22) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_x_value <= x;
    do begin
      @(negedge clk);
      b = busy;
      if (!b) begin
        if (typed) begin
          exp_r.val = want;
          exp_r.sat = 1'b0;
        end else begin
          exp_r = normal_eval(req, x);
        end
        pending.push_back(exp_r);
      end
      @(posedge clk);
    end while (b);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  always @(posedge clk) begin
    eval_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        e = pending.pop_front();
        if (out_result_value !== e.val)
          report($sformatf("result_value %h, want %h", out_result_value, e.val));
        if (out_saturated !== e.sat)
          report($sformatf("saturated %b, want %b", out_saturated, e.sat));
      end
    end
    if (cycles >= MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("gaussian_pdf_cdf_eval_top regression: fail");
      $finish;
    end
  end

  vec_t dir_tab[] = '{
    '{1'b0, 32'h0000_0000, 1'b1, 32'd26145},   // peak density, z = 0
    '{1'b1, 32'h0000_0000, 1'b0, 32'd0},
    '{1'b0, 32'h7FFF_FFFF, 1'b1, 32'd0},       // far tails
    '{1'b1, 32'h7FFF_FFFF, 1'b1, 32'd65536},
    '{1'b0, 32'h8000_0000, 1'b1, 32'd0},
    '{1'b1, 32'h8000_0000, 1'b1, 32'd0},
    '{1'b1, 32'h000F_0000, 1'b1, 32'd65536},
    '{1'b1, 32'hFFF1_0000, 1'b1, 32'd0},
    '{1'b0, 32'h0008_0000, 1'b1, 32'd0},       // z*z/2 reaches 32 exactly
    '{1'b1, 32'h0008_0000, 1'b1, 32'd65536},
    '{1'b1, 32'hFFF8_0000, 1'b1, 32'd0},
    '{1'b0, 32'h0007_FFFF, 1'b0, 32'd0},
    '{1'b1, 32'h0007_FFFF, 1'b0, 32'd0},
    '{1'b0, 32'h0001_0000, 1'b0, 32'd0},
    '{1'b1, 32'h0001_0000, 1'b0, 32'd0},
    '{1'b1, 32'hFFFF_0000, 1'b0, 32'd0},
    '{1'b1, 32'h0000_0001, 1'b0, 32'd0},
    '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'd0},
    '{1'b0, 32'hFFFF_FFFF, 1'b0, 32'd0},
    '{1'b1, 32'h0010_0000, 1'b0, 32'd0}       // |z| = 16 clamp
  };

  initial begin
    logic [31:0] m, s, x;
    cur_mean = 32'd0;
    cur_isig = 32'd1 << FB;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send(dir_tab[i].req, dir_tab[i].x, dir_tab[i].typed, dir_tab[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin m = 32'h8000_0000; s = 32'd1; end
        1: begin m = 32'h7FFF_FFFF; s = 32'hFFFF_FFFF; end
        2: begin m = 32'd0; s = 32'd1 << FB; end
        3: begin m = $urandom; s = 32'd1 << FB; end
        default: begin
          m = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
          s = $urandom_range(1 << (FB - 4), 1 << (FB + 4));
        end
      endcase
      cfg_write(gpdf_pkg::REG_MEAN, m);
      cfg_write(gpdf_pkg::REG_INV_SIGMA, s);
      no_gaps = (ph == 4);
      for (int i = 0; i < PER_PHASE; i++) begin
        // mostly near the mean, where both curves are not flat
        if ($urandom_range(99) < 70)
          x = cur_mean + ($urandom_range(0, 32'h000C_0000) - 32'h0006_0000);
        else
          x = $urandom;
        send(1'(($urandom)), x, 1'b0, 32'd0);
      end
      no_gaps = 1'b0;
    end

    settle();
    if (errors == 0)
      $display("gaussian_pdf_cdf_eval_top regression: pass");
    else
      $display("gaussian_pdf_cdf_eval_top regression: fail");
    $finish;
  end

endmodule

FILE: gaussian_pdf_cdf_eval_top.f
rtl/gpdf_pkg.sv
rtl/gpdf_recip.sv
rtl/gpdf_exp.sv
rtl/gaussian_pdf_cdf_eval_top.sv
tb/sv/testbench.sv
